FILE: rtl/tflut_pkg.sv
package tflut_pkg;
  localparam int MaxPoints = 16;
  localparam int MaxSamples = 4096;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int PosW = 17;
  localparam int ChW = 19;
  localparam int ScW = 13;
  localparam int KW = 12;
  localparam int StW = 3;
  localparam logic [PosW-1:0] PosOne = 17'd65536;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpSample = 2'd2;
  localparam logic [1:0] OpIgnored = 2'd3;

  localparam logic [StW-1:0] StOk = 3'd0;
  localparam logic [StW-1:0] StFull = 3'd1;
  localparam logic [StW-1:0] StDupIns = 3'd2;
  localparam logic [StW-1:0] StFew = 3'd3;
  localparam logic [StW-1:0] StHasDup = 3'd4;
  localparam logic [StW-1:0] StRange = 3'd5;

  typedef logic signed [ChW-1:0] chan_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } point_t;

  function automatic logic [7:0] to_byte(input logic signed [ChW+1:0] c);
    logic [16:0] cl;
    logic [25:0] p;
    begin
      if (c < 0) cl = '0;
      else if (c > $signed({4'd0, PosOne})) cl = PosOne;
      else cl = c[16:0];
      p = {9'd0, cl} * 26'd255 + 26'd32768;
      to_byte = p[23:16];
    end
  endfunction
endpackage

FILE: rtl/tflut_div.sv
module tflut_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [31:0] quo
);
  import tflut_pkg::*;
  logic [31:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] d_r;
  logic [4:0] cnt_r;
  logic run_r, done_r;
  logic [17:0] trial;

  always_comb begin
    trial = {rem_r[16:0], q_r[31]};
    q_nxt = {q_r[30:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = trial - {1'b0, d_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 5'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r <= num;
      rem_r <= '0;
      d_r <= den;
    end else if (run_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

FILE: rtl/transfer_function_lut_sampler_top.sv
// Clear, ignored opcodes and refused items go from decode straight to the done state; an
// insert scans the table and shifts entries up to its slot; a sample runs one 32-step serial
// division for the position and, inside a segment, a second one for the fraction t.
// busy stays high until out_valid, so a new transaction is taken only after the last is done.
// The receiver cannot stall. Synchronous active-low reset empties the table, clears the
// duplicate flag and sets sample_count to 256.
module transfer_function_lut_sampler_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_opcode,
  input  logic [16:0] in_point_position,
  input  logic signed [18:0] in_point_red,
  input  logic signed [18:0] in_point_green,
  input  logic signed [18:0] in_point_blue,
  input  logic signed [18:0] in_point_alpha,
  input  logic [11:0] in_sample_index,
  input  logic cfg_we,
  input  logic [12:0] cfg_sample_count,
  output logic out_valid,
  output logic [2:0] out_status,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic [4:0] out_points_held
);
  import tflut_pkg::*;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SDec = 4'd1;
  localparam logic [3:0] SScan = 4'd2;
  localparam logic [3:0] SShift = 4'd3;
  localparam logic [3:0] SDiv1 = 4'd4;
  localparam logic [3:0] SSeek = 4'd5;
  localparam logic [3:0] SLoadL = 4'd6;
  localparam logic [3:0] SDiv2 = 4'd7;
  localparam logic [3:0] SMul = 4'd8;
  localparam logic [3:0] SDone = 4'd9;
  localparam logic [3:0] SEnd = 4'd10;

  point_t mem [MaxPoints];
  logic [3:0] st_r;
  logic [CntW-1:0] cnt_r, i_r;
  logic dup_r, dflag_r;
  logic [ScW-1:0] sc_r;
  logic [1:0] op_r;
  point_t in_r, rd_r, lp_r;
  logic [KW-1:0] k_r;
  logic [PosW-1:0] pos_r;
  logic [IdxW-1:0] at_r;
  logic [16:0] t_r;
  logic [1:0] ch_r;
  logic [7:0] b_r [4];
  logic [StW-1:0] stat_r;
  logic ov_r;
  logic dgo;
  logic [31:0] dnum, dquo;
  logic [16:0] dden;
  logic ddone;
  logic [IdxW-1:0] raddr;
  chan_t ca, cb;
  logic signed [20:0] diff;
  logic signed [38:0] prod;
  logic signed [22:0] fl;

  tflut_div u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  assign busy = (st_r != SIdle);
  assign raddr = i_r[IdxW-1:0];

  always_ff @(posedge clk) rd_r <= mem[raddr];

  always_comb begin
    unique case (ch_r)
      2'd0: begin ca = lp_r.red; cb = rd_r.red; end
      2'd1: begin ca = lp_r.green; cb = rd_r.green; end
      2'd2: begin ca = lp_r.blue; cb = rd_r.blue; end
      default: begin ca = lp_r.alpha; cb = rd_r.alpha; end
    endcase
    diff = 21'(cb) - 21'(ca);
    prod = 39'(diff) * $signed({1'b0, t_r});
    fl = 23'(prod >>> 16);
  end

  always_comb begin
    dgo = 1'b0;
    dnum = {4'd0, k_r, 16'd0};
    dden = 17'(sc_r - 13'd1);
    if (st_r == SDec && op_r == OpSample) dgo = 1'b1;
    if (st_r == SLoadL) begin
      dgo = 1'b1;
      dnum = {16'(pos_r - lp_r.pos), 16'd0};
      dden = rd_r.pos - lp_r.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SIdle;
      cnt_r <= '0;
      dup_r <= 1'b0;
      sc_r <= 13'd256;
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_we) sc_r <= cfg_sample_count;
      unique case (st_r)
        SIdle: if (start) begin
          st_r <= SDec;
          for (int j = 0; j < 4; j++) b_r[j] <= '0;
        end
        SDec: begin
          stat_r <= StOk;
          st_r <= SDone;
          if (op_r == OpClear) begin
            cnt_r <= '0;
            dup_r <= 1'b0;
          end else if (op_r == OpInsert) begin
            if (cnt_r >= CntW'(MaxPoints)) stat_r <= StFull;
            else if (in_r.pos > PosOne) stat_r <= StRange;
            else begin
              i_r <= '0;
              at_r <= IdxW'(cnt_r);
              dflag_r <= 1'b0;
              st_r <= SScan;
            end
          end else if (op_r == OpSample) begin
            if (sc_r < 13'd2 || sc_r > 13'(MaxSamples)) stat_r <= StRange;
            else if (cnt_r < CntW'(2)) stat_r <= StFew;
            else if (dup_r) stat_r <= StHasDup;
            else if ({1'b0, k_r} >= sc_r) stat_r <= StRange;
            else begin
              i_r <= '0;
              st_r <= SDiv1;
            end
          end
        end
        SScan: begin
          if (i_r == cnt_r) begin
            st_r <= SShift;
          end else begin
            i_r <= i_r + CntW'(1);
            st_r <= SEnd;
          end
        end
        SEnd: begin
          if (rd_r.pos == in_r.pos) dflag_r <= 1'b1;
          if (rd_r.pos > in_r.pos && at_r == IdxW'(cnt_r) && IdxW'(i_r - 1) < at_r
              && i_r - CntW'(1) < cnt_r)
            at_r <= IdxW'(i_r - CntW'(1));
          st_r <= SScan;
        end
        SShift: begin
          if (i_r[CntW-1] || i_r < CntW'(at_r)) begin
            st_r <= SDone;
            cnt_r <= cnt_r + CntW'(1);
            if (dflag_r) begin
              dup_r <= 1'b1;
              stat_r <= StDupIns;
            end
          end else begin
            i_r <= i_r - CntW'(1);
          end
        end
        SDiv1: if (ddone) begin
          pos_r <= dquo[16:0];
          i_r <= '0;
          st_r <= SSeek;
        end
        SSeek: begin
          if (pos_r <= mem[0].pos) begin
            lp_r <= mem[0];
            t_r <= '0;
            i_r <= '0;
            ch_r <= 2'd0;
            st_r <= SMul;
          end else if (pos_r >= mem[IdxW'(cnt_r - CntW'(1))].pos) begin
            lp_r <= mem[IdxW'(cnt_r - CntW'(1))];
            t_r <= '0;
            i_r <= cnt_r - CntW'(1);
            ch_r <= 2'd0;
            st_r <= SMul;
          end else if (i_r == '0) begin
            i_r <= CntW'(1);
          end else if (pos_r > mem[raddr].pos) begin
            i_r <= i_r + CntW'(1);
          end else begin
            lp_r <= mem[IdxW'(i_r - CntW'(1))];
            st_r <= SLoadL;
          end
        end
        SLoadL: st_r <= SDiv2;
        SDiv2: if (ddone) begin
          t_r <= dquo[16:0];
          ch_r <= 2'd0;
          st_r <= SMul;
        end
        SMul: begin
          b_r[ch_r] <= to_byte(21'(ca) + 21'(fl));
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd3) st_r <= SDone;
        end
        SDone: begin
          ov_r <= 1'b1;
          st_r <= SIdle;
        end
        default: st_r <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == SIdle && start) begin
      op_r <= in_opcode;
      in_r <= '{in_point_position, in_point_red, in_point_green, in_point_blue,
                in_point_alpha};
      k_r <= in_sample_index;
    end
    if (st_r == SShift && !(i_r[CntW-1] || i_r < CntW'(at_r))) begin
      if (i_r == CntW'(at_r)) mem[raddr] <= in_r;
      else mem[raddr] <= mem[IdxW'(i_r - CntW'(1))];
    end
  end

  always_comb begin
    out_valid = ov_r;
    out_status = stat_r;
    out_red = b_r[0];
    out_green = b_r[1];
    out_blue = b_r[2];
    out_alpha = b_r[3];
    out_points_held = 5'(cnt_r);
  end
endmodule
